// File: design/mmuwe_pkg.sv
// Shared types, codes and saturation helpers for the utility-work evaluator.
// No dependencies; the evaluator, station-eval and checker files refer to this package by scope.
`default_nettype none

package mmuwe_pkg;

  // Opcodes carried in the input beat
  localparam logic [1:0] OP_START     = 2'd0;
  localparam logic [1:0] OP_LOAD_TIME = 2'd1;
  localparam logic [1:0] OP_LOAD_LEN  = 2'd2;
  localparam logic [1:0] OP_PROCESS   = 2'd3;

  // Configuration register indexes
  localparam int         CFG_IDX_W        = 1;
  localparam logic [0:0] REG_CYCLE_TIME   = 1'd0;
  localparam logic [0:0] REG_ACTIVE_STA   = 1'd1;
  localparam logic [15:0] CYCLE_TIME_RST  = 16'd81;
  localparam logic [4:0]  ACTIVE_STA_RST  = 5'd15;

  localparam logic [19:0] SAT20_MAX = 20'hFFFFF;
  localparam logic [31:0] SAT32_MAX = 32'hFFFFFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  station;
    logic [3:0]  model;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [19:0] item_utility;
    logic [31:0] total_utility;
    logic [19:0] position_sum;
    logic [31:0] fitness;
  } out_item_t;

  // One station's evaluation result
  typedef struct packed {
    logic [16:0] work;
    logic [15:0] new_pos;
  } eval_t;

  function automatic logic [19:0] sat20(input logic [31:0] v);
    sat20 = (v > 32'(SAT20_MAX)) ? SAT20_MAX : v[19:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [32:0] v);
    sat32 = v[32] ? SAT32_MAX : v[31:0];
  endfunction

endpackage

`default_nettype wire

// File: design/mmuwe_time_mem.sv
// Processing-time table: one write port, one registered read port.
// Depends on nothing; addressed as station * MAX_MODELS + model.
`default_nettype none

module mmuwe_time_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/mmuwe_station_mem.sv
// Per-station memory holding {length, operator position}, registered read.
// Position valid bits (cleared by reset and start) make stale positions read 0.
`default_nettype none

module mmuwe_station_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [15:0]   rd_len,
  output logic      [15:0]   rd_pos,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [15:0]   wr_len,
  input  wire logic [15:0]   wr_pos
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] pos_valid;
  logic [31:0]      rd_word;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_pos};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid <= pos_valid[rd_addr];
      end
      if (wr_en) begin
        pos_valid[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_len = rd_word[31:16];
  assign rd_pos = rd_valid ? rd_word[15:0] : 16'd0;

endmodule

`default_nettype wire

// File: design/mmuwe_station_eval.sv
// Utility work and next operator position for one station.
// Depends on mmuwe_pkg (eval_t).
`default_nettype none

module mmuwe_station_eval (
  input  wire logic [15:0]    proc_time,
  input  wire logic [15:0]    len,
  input  wire logic [15:0]    pos,
  input  wire logic [15:0]    cyc,
  output mmuwe_pkg::eval_t    res
);

  logic [16:0] reach;

  assign reach = {1'b0, pos} + {1'b0, proc_time};

  always_comb begin
    if (reach < {1'b0, len}) begin
      // operator finishes inside the station
      res.work    = 17'd0;
      res.new_pos = (reach > {1'b0, cyc}) ? 16'(reach - {1'b0, cyc}) : 16'd0;
    end else begin
      // runs past the station end: excess is utility work, clamp at the border
      res.work    = reach - {1'b0, len};
      res.new_pos = (len > cyc) ? 16'(len - cyc) : 16'd0;
    end
  end

endmodule

`default_nettype wire

// File: design/mixed_model_utility_work_evaluator.sv
// Mixed-model sequencing utility-work evaluator: top level and sequencer.
// Depends on mmuwe_pkg, mmuwe_time_mem, mmuwe_station_mem, mmuwe_station_eval.
//
//   channel  | signals                                   | beat moves when
//   ---------+-------------------------------------------+---------------------------
//   item     | item_valid, item_stall, item (in_item_t)  | item_valid && !item_stall
//   result   | result_valid, result_stall, result        | result_valid && !result_stall
//   config   | cfg_we, cfg_index, cfg_data               | cfg_we
//
// Process beat: n stations, n = min(active_stations, MAX_STATIONS), are walked
// one station per cycle through the time-table and station-memory read ports, then
// total/emit.
// Start and time load go straight to emit; length load is a read-modify-write of a station.
// Synchronous reset; positions read as zero until written, no clearing pass.
// A new item is taken while the previous result waits; emit holds on result_stall.
`default_nettype none

module mixed_model_utility_work_evaluator #(
  parameter int MAX_STATIONS = 16,
  parameter int MAX_MODELS   = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire mmuwe_pkg::in_item_t                item,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output mmuwe_pkg::out_item_t                    result,
  input  wire logic                               cfg_we,
  input  wire logic [mmuwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                        cfg_data
);

  localparam int TDEPTH = MAX_STATIONS * MAX_MODELS;
  localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int SAW    = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_STATIONS + 1);
  localparam int IW     = 17 + CNT_W;
  localparam int PSW    = 16 + CNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LRD  = 6'b000010,
    S_LWR  = 6'b000100,
    S_RUN  = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [15:0]      cycle_time;
  logic [4:0]       active_stations;

  logic [SAW-1:0]   st_q;
  logic [3:0]       md_q;
  logic             md_ok;
  logic [15:0]      val_q;
  logic [CNT_W-1:0] n_sta;
  logic [CNT_W-1:0] rd_idx;
  logic             pipe_v;
  logic [SAW-1:0]   pipe_idx;
  logic [IW-1:0]    item_sum;
  logic [31:0]      total;
  logic [PSW-1:0]   pos_total;

  logic             accept;
  logic             st_in_ok;
  logic             md_in_ok;
  logic [CNT_W-1:0] n_in;
  logic             issue;

  logic             t_rd_en;
  logic [TAW-1:0]   t_rd_addr;
  logic [15:0]      t_rd_data;
  logic             t_wr_en;
  logic [TAW-1:0]   t_wr_addr;

  logic             s_clear;
  logic             s_rd_en;
  logic [SAW-1:0]   s_rd_addr;
  logic [15:0]      s_rd_len;
  logic [15:0]      s_rd_pos;
  logic             s_wr_en;
  logic [SAW-1:0]   s_wr_addr;
  logic [15:0]      s_wr_len;
  logic [15:0]      s_wr_pos;

  logic [15:0]      t_eff;
  mmuwe_pkg::eval_t ev;
  logic [19:0]      ps20;

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign st_in_ok   = 32'(item.station) < MAX_STATIONS;
  assign md_in_ok   = 32'(item.model) < MAX_MODELS;
  assign n_in       = (32'(active_stations) > MAX_STATIONS) ? CNT_W'(MAX_STATIONS)
                                                            : CNT_W'(active_stations);
  assign issue      = (state == S_RUN) && (rd_idx != n_sta);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_time      <= mmuwe_pkg::CYCLE_TIME_RST;
      active_stations <= mmuwe_pkg::ACTIVE_STA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mmuwe_pkg::REG_CYCLE_TIME: cycle_time      <= cfg_data;
        mmuwe_pkg::REG_ACTIVE_STA: active_stations <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Time table: written straight from the accepted beat
  assign t_wr_en   = accept && (item.opcode == mmuwe_pkg::OP_LOAD_TIME) && st_in_ok && md_in_ok;
  assign t_wr_addr = TAW'(32'(item.station) * MAX_MODELS + 32'(item.model));
  assign t_rd_en   = issue;
  assign t_rd_addr = TAW'(32'(rd_idx) * MAX_MODELS + 32'(md_q));

  mmuwe_time_mem #(
    .DEPTH (TDEPTH),
    .AW    (TAW)
  ) u_tmem (
    .clk     (clk),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .rd_data (t_rd_data),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_data (item.value)
  );

  // Station memory: length-load read-modify-write, or per-station writeback
  assign s_clear   = accept && (item.opcode == mmuwe_pkg::OP_START);
  assign s_rd_en   = (state == S_LRD) || issue;
  assign s_rd_addr = (state == S_LRD) ? st_q : rd_idx[SAW-1:0];
  assign s_wr_en   = (state == S_LWR) || pipe_v;
  assign s_wr_addr = (state == S_LWR) ? st_q : pipe_idx;
  assign s_wr_len  = (state == S_LWR) ? val_q : s_rd_len;
  assign s_wr_pos  = (state == S_LWR) ? s_rd_pos : ev.new_pos;

  mmuwe_station_mem #(
    .DEPTH (MAX_STATIONS),
    .AW    (SAW)
  ) u_smem (
    .clk     (clk),
    .rst     (rst),
    .clear   (s_clear),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_len  (s_rd_len),
    .rd_pos  (s_rd_pos),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_len  (s_wr_len),
    .wr_pos  (s_wr_pos)
  );

  assign t_eff = md_ok ? t_rd_data : 16'd0;

  mmuwe_station_eval u_eval (
    .proc_time (t_eff),
    .len       (s_rd_len),
    .pos       (s_rd_pos),
    .cyc       (cycle_time),
    .res       (ev)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item.opcode)
            mmuwe_pkg::OP_LOAD_LEN: state_next = st_in_ok ? S_LRD : S_EMIT;
            mmuwe_pkg::OP_PROCESS:  state_next = (n_in != '0) ? S_RUN : S_FIN;
            default:                state_next = S_EMIT;
          endcase
        end
      end
      S_LRD:  state_next = S_LWR;
      S_LWR:  state_next = S_EMIT;
      S_RUN:  state_next = (!issue && pipe_v) ? S_FIN : S_RUN;
      S_FIN:  state_next = S_EMIT;
      S_EMIT: state_next = (!result_valid || !result_stall) ? S_IDLE : S_EMIT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pipe_v    <= 1'b0;
      total     <= '0;
      pos_total <= '0;
    end else begin
      state  <= state_next;
      pipe_v <= issue;
      if (s_clear) begin
        total     <= '0;
        pos_total <= '0;
      end else if (pipe_v) begin
        pos_total <= pos_total - PSW'(s_rd_pos) + PSW'(ev.new_pos);
      end
      if (state == S_FIN) begin
        total <= mmuwe_pkg::sat32({1'b0, total} + 33'(item_sum));
      end
    end
  end

  // Beat fields and station walk
  always_ff @(posedge clk) begin
    if (accept) begin
      st_q     <= SAW'(item.station);
      md_q     <= item.model;
      md_ok    <= md_in_ok;
      val_q    <= item.value;
      n_sta    <= n_in;
      rd_idx   <= '0;
      item_sum <= '0;
    end else begin
      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (pipe_v) begin
        item_sum <= item_sum + IW'(ev.work);
      end
    end
    pipe_idx <= rd_idx[SAW-1:0];
  end

  assign ps20 = mmuwe_pkg::sat20(32'(pos_total));

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_EMIT) && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!result_valid || !result_stall)) begin
      result.item_utility  <= mmuwe_pkg::sat20(32'(item_sum));
      result.total_utility <= total;
      result.position_sum  <= ps20;
      result.fitness       <= mmuwe_pkg::sat32({1'b0, total} + 33'(ps20));
    end
  end

endmodule

`default_nettype wire

// File: design/mmuwe_checker.sv
// Port-level checks for the utility-work evaluator, bound to the top level.
// Depends on mmuwe_pkg and mixed_model_utility_work_evaluator.
`default_nettype none

module mmuwe_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            item_valid,
  input wire logic                            item_stall,
  input wire logic                            result_valid,
  input wire logic                            result_stall,
  input wire mmuwe_pkg::out_item_t            result
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // one beat in flight: busy the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken while previous beat in progress");

  // held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // fitness never below either of its terms
  a_fitness_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.fitness >= result.total_utility) &&
                     (result.fitness >= 32'(result.position_sum)))
    else $error("fitness below total or position sum");

  // with no utility, fitness is just the position sum
  a_fitness_zero_total: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.total_utility == 32'd0)) |->
      (result.fitness == 32'(result.position_sum)))
    else $error("fitness mismatch at zero total");

endmodule

bind mixed_model_utility_work_evaluator mmuwe_checker u_mmuwe_checker (.*);

`default_nettype wire
